### hdl/cop_pkg.sv
// ----------------------------------------------------------------------------
// cop_pkg
// Shared constants, register codes and tables for the circular orbit block.
// ----------------------------------------------------------------------------
package cop_pkg;

  localparam int DAY_W      = 20;
  localparam int RADIUS_W   = 16;
  localparam int PERIOD_W   = 24;
  localparam int POS_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam int DEF_CORDIC_STAGES = 16;
  localparam int DEF_PHASE_BITS    = 16;
  localparam int TABLE_LEN         = 24;

  // Remainder numerator: day*128 is 27 bits wide.
  localparam int NUM_W = DAY_W + 7;

  // CORDIC datapath: x0 < 2^16 * 2^14 = 2^30; growth below 1.65, keep sign.
  localparam int CW = 33;
  localparam int ZW = 32;

  localparam logic [29:0] GAIN_Q30 = 30'd652032874;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd1024;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd46753;
  localparam int OUT_MAX = 65535;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 1'b0,
    REG_PERIOD = 1'b1
  } cfg_reg_e;

  // Angle table, atan(2^-i) in 2^32-per-turn units.
  function automatic logic [ZW-1:0] atan_turn(input int idx);
    logic [ZW-1:0] v;
    begin
      case (idx)
        0:  v = 32'd536870912;
        1:  v = 32'd316933406;
        2:  v = 32'd167458907;
        3:  v = 32'd85004756;
        4:  v = 32'd42667331;
        5:  v = 32'd21354465;
        6:  v = 32'd10679838;
        7:  v = 32'd5340245;
        8:  v = 32'd2670163;
        9:  v = 32'd1335087;
        10: v = 32'd667544;
        11: v = 32'd333772;
        12: v = 32'd166886;
        13: v = 32'd83443;
        14: v = 32'd41722;
        15: v = 32'd20861;
        16: v = 32'd10430;
        17: v = 32'd5215;
        18: v = 32'd2608;
        19: v = 32'd1304;
        20: v = 32'd652;
        21: v = 32'd326;
        22: v = 32'd163;
        23: v = 32'd81;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

### hdl/circular_orbit_position_top.sv
// Pipeline: the divider steps, a gain register, the CORDIC rotation steps and an output register.
// Throughput: one day word per cycle; every divider bit and CORDIC step has its register.
// busy is always low; results appear with done_o for one cycle and cannot be stalled.
// Reset clears all valid bits and loads radius 1.0 AU and period 46753.
// ----------------------------------------------------------------------------
// circular_orbit_position_top
// Day number to x/y position on a circular orbit.
// ----------------------------------------------------------------------------
module circular_orbit_position_top
  import cop_pkg::*;
#(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
  parameter int PHASE_BITS    = DEF_PHASE_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    start,
  output logic                    busy,
  input  logic [DAY_W-1:0]        day_number_i,
  output logic                    done_o,
  output logic signed [POS_W-1:0] pos_x_o,
  output logic signed [POS_W-1:0] pos_y_o
);

  logic [RADIUS_W-1:0] radius_q;
  logic [PERIOD_W-1:0] period_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      period_q <= PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS: radius_q <= cfg_data_i[RADIUS_W-1:0];
        REG_PERIOD: period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic                  dv;
  logic [PHASE_BITS-1:0] phase;
  logic [RADIUS_W-1:0]   drad;

  cop_divider #(.PHASE_BITS(PHASE_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .day_i   (day_number_i),
    .period_i(period_q),
    .radius_i(radius_q),
    .valid_o (dv),
    .phase_o (phase),
    .radius_o(drad)
  );

  cop_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .PHASE_BITS(PHASE_BITS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv),
    .phase_i (phase),
    .radius_i(drad),
    .valid_o (done_o),
    .pos_x_o (pos_x_o),
    .pos_y_o (pos_y_o)
  );

endmodule

### hdl/cop_div_stage.sv
// ----------------------------------------------------------------------------
// cop_div_stage
// One registered restoring-division step: shifts in one numerator bit,
// subtracts the divisor when it fits and records the quotient bit.
// ----------------------------------------------------------------------------
module cop_div_stage
  import cop_pkg::*;
#(
  parameter int QW = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [PERIOD_W-1:0] den_i,
  input  logic [PERIOD_W:0]   rem_i,
  input  logic [QW-1:0]       num_i,
  input  logic [QW-1:0]       quo_i,
  input  logic [RADIUS_W-1:0] radius_i,
  input  logic                bit_i,
  output logic                valid_o,
  output logic [PERIOD_W-1:0] den_o,
  output logic [PERIOD_W:0]   rem_o,
  output logic [QW-1:0]       num_o,
  output logic [QW-1:0]       quo_o,
  output logic [RADIUS_W-1:0] radius_o
);

  logic [PERIOD_W+1:0] trial;
  logic                fits;
  logic [PERIOD_W:0]   rem_d;

  // Try the subtract on the shifted remainder
  always_comb begin
    trial = {rem_i, bit_i};
    fits  = trial >= {2'b00, den_i};
    rem_d = fits ? (PERIOD_W+1)'(trial - {2'b00, den_i}) : trial[PERIOD_W:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_o    <= den_i;
    rem_o    <= rem_d;
    num_o    <= num_i;
    quo_o    <= {quo_i[QW-2:0], fits};
    radius_o <= radius_i;
  end

endmodule

### hdl/cop_divider.sv
// ----------------------------------------------------------------------------
// cop_divider
// Pipelined phase divider: computes (day*128) mod period, then the phase
// fraction rem*2^PHASE_BITS / period, one bit per stage.
// ----------------------------------------------------------------------------
module cop_divider
  import cop_pkg::*;
#(
  parameter int PHASE_BITS = DEF_PHASE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [DAY_W-1:0]      day_i,
  input  logic [PERIOD_W-1:0]   period_i,
  input  logic [RADIUS_W-1:0]   radius_i,
  output logic                  valid_o,
  output logic [PHASE_BITS-1:0] phase_o,
  output logic [RADIUS_W-1:0]   radius_o
);

  localparam int NS = NUM_W + PHASE_BITS;
  localparam int QW = NS;

  logic                v   [NS+1];
  logic [PERIOD_W-1:0] den [NS+1];
  logic [PERIOD_W:0]   rem [NS+1];
  logic [QW-1:0]       num [NS+1];
  logic [QW-1:0]       quo [NS+1];
  logic [RADIUS_W-1:0] rad [NS+1];

  // Numerator bits first, then PHASE_BITS zeros for the fraction
  assign v[0]   = valid_i;
  assign den[0] = period_i;
  assign rem[0] = '0;
  assign num[0] = QW'({day_i, 7'd0}) << PHASE_BITS;
  assign quo[0] = '0;
  assign rad[0] = radius_i;

  for (genvar s = 0; s < NS; s++) begin : g_step
    cop_div_stage #(.QW(QW)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[s]),
      .den_i   (den[s]),
      .rem_i   (rem[s]),
      .num_i   ({num[s][QW-2:0], 1'b0}),
      .quo_i   (quo[s]),
      .radius_i(rad[s]),
      .bit_i   (num[s][QW-1]),
      .valid_o (v[s+1]),
      .den_o   (den[s+1]),
      .rem_o   (rem[s+1]),
      .num_o   (num[s+1]),
      .quo_o   (quo[s+1]),
      .radius_o(rad[s+1])
    );
  end

  // Division of (a*2^P) by d gives floor(a mod d * 2^P / d) in the low bits.
  // Zero period forces zero phase.
  assign valid_o  = v[NS];
  assign phase_o  = (den[NS] == '0) ? '0 : quo[NS][PHASE_BITS-1:0];
  assign radius_o = rad[NS];

endmodule

### hdl/cop_cordic.sv
// ----------------------------------------------------------------------------
// cop_cordic
// Gain scaling, pipelined CORDIC rotation, quadrant map, round and saturate.
// ----------------------------------------------------------------------------
module cop_cordic
  import cop_pkg::*;
#(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
  parameter int PHASE_BITS    = DEF_PHASE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [PHASE_BITS-1:0]  phase_i,
  input  logic [RADIUS_W-1:0]    radius_i,
  output logic                   valid_o,
  output logic signed [POS_W-1:0] pos_x_o,
  output logic signed [POS_W-1:0] pos_y_o
);

  localparam int NS = CORDIC_STAGES;

  logic                 v_q [NS+1];
  logic signed [CW-1:0] x_q [NS+1];
  logic signed [CW-1:0] y_q [NS+1];
  logic signed [ZW:0]   z_q [NS+1];
  logic [1:0]           qd_q [NS+1];

  logic [ZW-1:0] turn;
  logic [45:0]   gain_prod;

  assign turn      = ZW'(phase_i) << (ZW - PHASE_BITS);
  assign gain_prod = {30'd0, radius_i} * {16'd0, GAIN_Q30};

  // Scale radius by the CORDIC gain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]  <= CW'(gain_prod[45:16]);
    y_q[0]  <= '0;
    z_q[0]  <= {3'b000, turn[29:0]};
    qd_q[0] <= turn[31:30];
  end

  // Rotation steps
  for (genvar i = 0; i < NS; i++) begin : g_rot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!z_q[i][ZW]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - $signed({1'b0, atan_turn(i)});
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + $signed({1'b0, atan_turn(i)});
      end
      qd_q[i+1] <= qd_q[i];
    end
  end

  logic signed [CW-1:0] rx, ry;
  logic signed [CW-1:0] sx, sy;
  logic signed [POS_W-1:0] ox_d, oy_d;
  logic ov_q;
  logic signed [POS_W-1:0] ox_q, oy_q;

  // Map quadrant
  always_comb begin
    case (qd_q[NS])
      2'd0:    begin rx = x_q[NS];  ry = y_q[NS];  end
      2'd1:    begin rx = -y_q[NS]; ry = x_q[NS];  end
      2'd2:    begin rx = -x_q[NS]; ry = -y_q[NS]; end
      default: begin rx = y_q[NS];  ry = -x_q[NS]; end
    endcase
    sx = (rx + CW'(8192)) >>> 14;
    sy = (ry + CW'(8192)) >>> 14;
  end

  function automatic logic signed [POS_W-1:0] sat(input logic signed [CW-1:0] a);
    logic signed [POS_W-1:0] r;
    begin
      if (a > CW'(OUT_MAX))       r = POS_W'(OUT_MAX);
      else if (a < -CW'(OUT_MAX)) r = -POS_W'(OUT_MAX);
      else                        r = a[POS_W-1:0];
      return r;
    end
  endfunction

  assign ox_d = sat(sx);
  assign oy_d = sat(sy);

  // Register the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q <= ox_d;
    oy_q <= oy_d;
  end

  assign valid_o = ov_q;
  assign pos_x_o = ox_q;
  assign pos_y_o = oy_q;

  a_sat_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (ox_q <= POS_W'(OUT_MAX) && ox_q >= -POS_W'(OUT_MAX)))
    else $error("pos_x out of range");
  a_sat_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (oy_q <= POS_W'(OUT_MAX) && oy_q >= -POS_W'(OUT_MAX)))
    else $error("pos_y out of range");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS] |=> ov_q)
    else $error("result word lost");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives day words into the circular orbit block and compares each x/y
// position with a fixed-point CORDIC prediction held in this bench.
// ----------------------------------------------------------------------------
module tb;
  import cop_pkg::*;

  localparam int STAGES  = DEF_CORDIC_STAGES;
  localparam int PH_BITS = DEF_PHASE_BITS;
  localparam int LATENCY = NUM_W + PH_BITS + STAGES + 2;

  typedef struct {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
  } position_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = REG_RADIUS;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [DAY_W-1:0]      day_number_i = '0;
  logic                  done_o;
  logic signed [POS_W-1:0] pos_x_o, pos_y_o;

  logic [RADIUS_W-1:0] radius_q = RADIUS_RST;
  logic [PERIOD_W-1:0] period_q = PERIOD_RST;
  position_t           pending_pos[$];
  int                  fault_cnt = 0;
  int                  idle_pct = 0;

  circular_orbit_position_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start, .busy,
    .day_number_i, .done_o, .pos_x_o, .pos_y_o
  );

  always #5 clk_i = ~clk_i;

  // Round to Q6.10 and clamp
  function automatic logic signed [POS_W-1:0] round_q10(input longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < -OUT_MAX) r = -OUT_MAX;
    return r[POS_W-1:0];
  endfunction

  // Phase from day, then rotate (radius*K, 0) by CORDIC steps
  function automatic position_t orbit_position(input logic [DAY_W-1:0] day);
    longint unsigned rem, phase;
    logic [31:0] turn;
    longint x, y, z, dx, dy, rx, ry;
    position_t p;
    phase = 0;
    if (period_q != 0) begin
      rem = (longint'(day) * 128) % period_q;
      phase = (rem << PH_BITS) / period_q;
    end
    phase &= (64'd1 << PH_BITS) - 1;
    turn = 32'(phase << (32 - PH_BITS));
    z = turn[29:0];
    x = (longint'(radius_q) * GAIN_Q30) >> 16;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_turn(i);
      end else begin
        x += dx; y -= dy; z += atan_turn(i);
      end
    end
    case (turn[31:30])
      2'd0: begin rx = x;  ry = y;  end
      2'd1: begin rx = -y; ry = x;  end
      2'd2: begin rx = -x; ry = -y; end
      default: begin rx = y; ry = -x; end
    endcase
    p.px = round_q10(rx);
    p.py = round_q10(ry);
    return p;
  endfunction

  // Check each result word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_pos.size() == 0) begin
        $error("unexpected word x=%0d y=%0d", pos_x_o, pos_y_o);
        fault_cnt++;
      end else begin
        position_t e;
        e = pending_pos.pop_front();
        if (pos_x_o !== e.px) begin
          $error("pos_x expected %0d actual %0d", e.px, pos_x_o);
          fault_cnt++;
        end
        if (pos_y_o !== e.py) begin
          $error("pos_y expected %0d actual %0d", e.py, pos_y_o);
          fault_cnt++;
        end
      end
    end
  end

  // Send one day word, with random idle cycles before it
  task automatic send_day(input logic [DAY_W-1:0] day);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    day_number_i <= day;
    do @(posedge clk_i); while (busy);
    pending_pos.push_back(orbit_position(day));
  endtask

  // Drain all words, then write one register
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    start <= 1'b0;
    while (pending_pos.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_RADIUS) radius_q = val[RADIUS_W-1:0];
    else period_q = val[PERIOD_W-1:0];
  endtask

  task automatic test_directed();
    logic [DAY_W-1:0] days[8] = '{20'd0, 20'd1, 20'd365, 20'd1023, 20'h55555, 20'hAAAAA,
                                  20'hFFFFE, 20'hFFFFF};
    foreach (days[i]) send_day(days[i]);
    // extreme radius, quarter turns exactly
    write_reg(REG_RADIUS, 24'hFFFF);
    write_reg(REG_PERIOD, 24'd512);
    for (int d = 0; d < 5; d++) send_day(DAY_W'(d));
    // zero period holds phase at zero
    write_reg(REG_PERIOD, 24'd0);
    send_day(20'd12345);
    send_day(20'hFFFFF);
    // shortest and longest period, zero radius
    write_reg(REG_PERIOD, 24'd1);
    send_day(20'd7);
    write_reg(REG_PERIOD, 24'hFFFFFF);
    send_day(20'hFFFFF);
    send_day(20'h80000);
    write_reg(REG_RADIUS, 24'd0);
    send_day(20'd100);
  endtask

  task automatic test_random(input int n, input int pct);
    idle_pct = pct;
    write_reg(REG_RADIUS, CFG_DATA_W'($urandom_range(1) ? $urandom() : $urandom_range(4096)));
    write_reg(REG_PERIOD, CFG_DATA_W'($urandom_range(1) ? $urandom() : $urandom_range(100000)));
    for (int k = 0; k < n; k++) begin
      send_day(DAY_W'($urandom()));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    for (int ph = 0; ph < 6; ph++) test_random(90, ph < 2 ? 24 : (ph < 4 ? 55 : 0));
    start <= 1'b0;
    while (pending_pos.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fault_cnt == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  // Time limit
  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end
endmodule
